// File: src/bdq_pkg.sv
// shared constants, codes and types of the bounded deque
package bdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 4;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    // index width wide enough for both the position field and the count
    localparam int IDX_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_READ       = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK
    } t_state;

    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [DATA_WIDTH-1:0] t_data;

endpackage

// File: src/bdq_if.sv
// command and result channel interfaces of the bounded deque
interface bdq_cmd_if;
    import bdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    t_data            value;
    logic [POS_W-1:0] position;

    modport source(output valid, output cmd, output value, output position, input ready);
    modport sink(input valid, input cmd, input value, input position, output ready);
endinterface

interface bdq_res_if;
    import bdq_pkg::*;

    logic                valid;
    logic                ready;
    t_data               read_value;
    t_count              count;
    logic [STATUS_W-1:0] status;

    modport source(output valid, output read_value, output count, output status, input ready);
    modport sink(input valid, input read_value, input count, input status, output ready);
endinterface

// File: src/bdq_ram.sv
// generic single-write, single-read ram with registered read data
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bounded_deque_with_key_removal_core.sv
// bounded deque with removal by value: linked slots held in three rams
//
// Usage: commands arrive on i_cmd (cmd, value, position) and each one gives
// exactly one transfer on o_res (read_value, count, status). Push back and
// push front take the lowest free slot and refuse with status full when all
// slots are used. Remove walks from the front and unlinks the first match;
// read walks from the front to the given position, clamped to the last entry.
// Clear empties the list. Unused command codes only report the count.
// Timing: one command is in flight at a time. Push, clear and commands that
// find the list empty fill the result register in the start step, once the
// result register is free. Remove and read go on to the walk step, which
// follows the next links one slot per cycle through the read port of the
// slot rams and visits 1 to 16 slots before it loads the result register.
// The next command is taken the cycle after the result register is loaded.
// A new command is accepted while an earlier result still waits on o_res;
// its execution holds at the start step until the result register is free.
// Reset (synchronous, active low) empties the list and drops any pending
// result; slot rams are not cleared since only linked slots are read.
module bounded_deque_with_key_removal_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bdq_cmd_if.sink  i_cmd,
    bdq_res_if.source o_res
);
    import bdq_pkg::*;

    t_state              r_state, n_state;
    t_slot               r_head, n_head;
    t_slot               r_tail, n_tail;
    t_count              r_count, n_count;
    logic [CAPACITY-1:0] r_free, n_free;
    t_slot               r_cur, n_cur;
    t_idx                r_idx, n_idx;

    logic [CMD_W-1:0]    r_cmd;
    t_data               r_value;
    t_idx                r_steps;

    logic                r_out_valid, n_out_valid;
    t_data               r_rd, n_rd;
    t_count              r_out_count, n_out_count;
    logic [STATUS_W-1:0] r_status, n_status;

    logic   accept;
    logic   out_free;
    t_slot  free_slot;
    t_idx   pos_ext;
    t_idx   count_ext;

    t_slot  raddr;
    t_data  rd_val;
    t_slot  rd_next;
    t_slot  rd_prev;
    logic   val_we, next_we, prev_we;
    t_slot  val_waddr, next_waddr, prev_waddr;
    t_slot  next_wdata, prev_wdata;

    bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_raddr (raddr),
        .o_rdata (rd_val)
    );

    bdq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_next)
    );

    bdq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_prev)
    );

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign accept           = i_cmd.valid && i_cmd.ready;
    assign out_free         = !r_out_valid || o_res.ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_rd;
    assign o_res.count      = r_out_count;
    assign o_res.status     = r_status;

    assign pos_ext   = IDX_W'(i_cmd.position);
    assign count_ext = IDX_W'(r_count);

    // lowest numbered free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_free      = r_free;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_rd        = r_rd;
        n_out_count = r_out_count;
        n_status    = r_status;
        raddr       = r_head;
        val_we      = 1'b0;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        val_waddr   = free_slot;
        next_waddr  = free_slot;
        prev_waddr  = free_slot;
        next_wdata  = free_slot;
        prev_wdata  = free_slot;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end

            S_START: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                    case (r_cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                val_we = 1'b1;
                                n_free[free_slot] = 1'b0;
                                n_count = r_count + 1'b1;
                                if (r_cmd == CMD_PUSH_BACK) begin
                                    prev_we    = 1'b1;
                                    prev_wdata = (r_count == '0) ? free_slot : r_tail;
                                    next_we    = (r_count != '0);
                                    next_waddr = r_tail;
                                    n_tail     = free_slot;
                                    if (r_count == '0) begin
                                        n_head = free_slot;
                                    end
                                end else begin
                                    next_we    = 1'b1;
                                    next_wdata = (r_count == '0) ? free_slot : r_head;
                                    prev_we    = (r_count != '0);
                                    prev_waddr = r_head;
                                    n_head     = free_slot;
                                    if (r_count == '0) begin
                                        n_tail = free_slot;
                                    end
                                end
                            end
                        end
                        CMD_REMOVE, CMD_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // head slot data arrives next cycle
                                n_out_valid = 1'b0;
                                raddr       = r_head;
                                n_cur       = r_head;
                                n_idx       = '0;
                                n_state     = S_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_free  = '1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end

            S_WALK: begin
                if (r_cmd == CMD_READ && r_idx == r_steps) begin
                    n_out_valid = 1'b1;
                    n_rd        = rd_val;
                    n_status    = ST_OK;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else if (r_cmd == CMD_REMOVE && rd_val == r_value) begin
                    // unlink the matching slot
                    next_we      = (r_idx != '0);
                    next_waddr   = rd_prev;
                    next_wdata   = rd_next;
                    prev_we      = (r_idx + 1'b1 != count_ext);
                    prev_waddr   = rd_next;
                    prev_wdata   = rd_prev;
                    if (r_idx == '0) begin
                        n_head = rd_next;
                    end
                    if (r_idx + 1'b1 == count_ext) begin
                        n_tail = rd_prev;
                    end
                    n_free[r_cur] = 1'b1;
                    n_count       = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_status    = ST_OK;
                    n_out_count = n_count;
                    n_state     = S_IDLE;
                end else if (r_cmd == CMD_REMOVE && r_idx + 1'b1 == count_ext) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_status    = ST_NOT_FOUND;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else begin
                    // follow the next link straight from the read data
                    raddr = rd_next;
                    n_cur = rd_next;
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_idx       <= n_idx;
        r_rd        <= n_rd;
        r_out_count <= n_out_count;
        r_status    <= n_status;
        if (accept) begin
            r_cmd   <= i_cmd.cmd;
            r_value <= i_cmd.value;
            // clamp a position past the end to the last entry
            r_steps <= (pos_ext < count_ext) ? pos_ext : count_ext - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_free_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_free) + int'(r_count)) == CAPACITY)
        else $error("free map and entry count disagree");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_START))
        else $error("accepted command did not start");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty list with nonzero head or tail");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx < count_ext))
        else $error("walk index past the end of the list");
`endif

endmodule
